// ----- rtl/core/otbm_pkg.sv -----
// shared types and constants for the owner tagged byte memory
`default_nettype none
package otbm_pkg;

  localparam int ADDR_BITS = 12;
  localparam int SIZE_BITS = 13;
  localparam int TAG_BITS  = 8;
  localparam int DATA_BITS = 8;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [TAG_BITS-1:0] NO_OWNER = 8'hFF;
  localparam logic REG_IDX_MEM_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_CLAIM   = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK               = 3'd0,
    ST_BAD_ADDR         = 3'd1,
    ST_OWNER_MISMATCH   = 3'd2,
    ST_END_BEFORE_START = 3'd3,
    ST_BAD_OWNER        = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_RUN,
    CS_WALK
  } ctl_state_t;

  typedef struct packed {
    op_t                        op;
    logic [ADDR_BITS-1:0]       addr;
    logic [ADDR_BITS-1:0]       end_addr;
    logic [DATA_BITS-1:0]       wdata;
    logic signed [TAG_BITS-1:0] owner_id;
  } in_item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] rdata;
    status_t              status;
    logic [SIZE_BITS-1:0] free_bytes;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] mem_size;
    logic [SIZE_BITS-1:0] eff_size;
    logic                 init;
    logic [SIZE_BITS-1:0] init_size;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/owner_tagged_byte_memory.sv -----
// byte reads/writes: one per cycle unless a walk or output stall holds them; result is registered
// claim/release: one tag read-modify-write per byte in the range,
// done by the single tag ram port pair walking the range
// after reset and after each mem_size write a clearing pass over the tag ram
// sets every tag to no owner; no transaction is accepted during it
// top level: owner tagged byte memory with free byte count
`default_nettype none
module owner_tagged_byte_memory
  import otbm_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire in_item_t                 in_item,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      out_item_t                out_item,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output      logic [APB_DATA_BITS-1:0] prdata,
  output      logic                     pready
);

  localparam int IDX_W = $clog2(MEM_BYTES);
  localparam int EXT_W = (IDX_W > ADDR_BITS) ? IDX_W : ADDR_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_BYTES - 1);
  localparam logic [SIZE_BITS-1:0] RESET_SIZE = SIZE_BITS'((MEM_BYTES < 4096) ? MEM_BYTES : 4096);

  function automatic logic [IDX_W-1:0] to_idx(input logic [ADDR_BITS-1:0] a);
    logic [EXT_W-1:0] e;
    e = EXT_W'(a);
    return e[IDX_W-1:0];
  endfunction

  cfg_t cfg;

  ctl_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r;

  logic     s1_valid_r;
  logic     s1_walked_r;
  in_item_t s1_item_r;

  logic                 fwd_valid_r;
  logic [ADDR_BITS-1:0] fwd_addr_r;
  logic [DATA_BITS-1:0] fwd_data_r;

  logic [ADDR_BITS-1:0] wk_rd_addr_r;
  logic                 wk_rd_more_r;
  logic                 wk_wb_valid_r;
  logic [ADDR_BITS-1:0] wk_wb_addr_r;

  logic [SIZE_BITS-1:0] free_r, free_nxt;

  logic      out_valid_r;
  out_item_t out_item_r;

  logic                 tag_we, tag_re, data_we, data_re;
  logic [IDX_W-1:0]     tag_waddr, tag_raddr;
  logic [TAG_BITS-1:0]  tag_wdata, tag_rdata;
  logic [DATA_BITS-1:0] data_rdata;

  logic                 accept;
  logic                 is_range, a0_ok, a1_ok, bad_owner, tag_hit;
  status_t              s1_status;
  logic                 range_go, s1_fire, out_free;
  logic [TAG_BITS-1:0]  new_tag;
  logic [DATA_BITS-1:0] data_fwd;
  logic                 clr_last, wk_last;
  logic                 was_free, now_free;

  otbm_cfg #(.MEM_BYTES(MEM_BYTES)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  otbm_ram #(.DATA_W(TAG_BITS), .DEPTH(MEM_BYTES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  otbm_ram #(.DATA_W(DATA_BITS), .DEPTH(MEM_BYTES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (to_idx(s1_item_r.addr)),
    .wdata (s1_item_r.wdata),
    .re    (data_re),
    .raddr (to_idx(in_item.addr)),
    .rdata (data_rdata)
  );

  // request checks
  assign is_range  = (s1_item_r.op == OP_CLAIM) || (s1_item_r.op == OP_RELEASE);
  assign a0_ok     = {1'b0, s1_item_r.addr} < cfg.eff_size;
  assign a1_ok     = {1'b0, s1_item_r.end_addr} < cfg.eff_size;
  assign bad_owner = s1_item_r.owner_id[TAG_BITS-1] && ($unsigned(s1_item_r.owner_id) != NO_OWNER);
  assign tag_hit   = tag_rdata == $unsigned(s1_item_r.owner_id);
  assign new_tag   = (s1_item_r.op == OP_CLAIM) ? $unsigned(s1_item_r.owner_id) : NO_OWNER;
  assign data_fwd  = (fwd_valid_r && (fwd_addr_r == s1_item_r.addr)) ? fwd_data_r : data_rdata;

  always_comb begin
    s1_status = ST_OK;
    if (!is_range) begin
      if (!a0_ok) begin
        s1_status = ST_BAD_ADDR;
      end else if (!tag_hit) begin
        s1_status = ST_OWNER_MISMATCH;
      end
    end else begin
      if (!a0_ok || !a1_ok) begin
        s1_status = ST_BAD_ADDR;
      end else if (s1_item_r.end_addr < s1_item_r.addr) begin
        s1_status = ST_END_BEFORE_START;
      end else if ((s1_item_r.op == OP_CLAIM) && bad_owner) begin
        s1_status = ST_BAD_OWNER;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign range_go = (state_r == CS_RUN) && s1_valid_r && is_range && (s1_status == ST_OK)
                    && !s1_walked_r;
  assign s1_fire  = (state_r == CS_RUN) && s1_valid_r && !range_go && out_free;
  assign accept   = in_valid && in_ready;
  assign clr_last = clr_idx_r == LAST_IDX;
  assign wk_last  = !wk_rd_more_r && wk_wb_valid_r;
  assign data_we  = s1_fire && (s1_item_r.op == OP_WRITE) && (s1_status == ST_OK);
  assign data_re  = accept;

  // next state
  always_comb begin
    state_nxt = state_r;
    priority if (cfg.init) begin
      state_nxt = CS_CLEAR;
    end else begin
      unique case (state_r)
        CS_CLEAR: begin
          if (clr_last) state_nxt = CS_RUN;
        end
        CS_RUN: begin
          if (range_go) state_nxt = CS_WALK;
        end
        CS_WALK: begin
          if (wk_last) state_nxt = CS_RUN;
        end
        default: state_nxt = CS_CLEAR;
      endcase
    end
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    tag_we    = 1'b0;
    tag_waddr = clr_idx_r;
    tag_wdata = NO_OWNER;
    tag_re    = 1'b0;
    tag_raddr = to_idx(in_item.addr);
    unique case (state_r)
      CS_CLEAR: begin
        tag_we = 1'b1;
      end
      CS_RUN: begin
        in_ready = !s1_valid_r || s1_fire;
        tag_re   = in_valid && in_ready;
      end
      CS_WALK: begin
        tag_we    = wk_wb_valid_r;
        tag_waddr = to_idx(wk_wb_addr_r);
        tag_wdata = new_tag;
        tag_re    = wk_rd_more_r;
        tag_raddr = to_idx(wk_rd_addr_r);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // free count update during the walk
  assign was_free = tag_rdata == NO_OWNER;
  assign now_free = new_tag == NO_OWNER;

  always_comb begin
    free_nxt = free_r;
    if ((state_r == CS_WALK) && wk_wb_valid_r) begin
      if (was_free && !now_free && (free_r != '0)) begin
        free_nxt = free_r - 1'b1;
      end else if (!was_free && now_free) begin
        free_nxt = free_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_CLEAR;
      clr_idx_r   <= '0;
      free_r      <= RESET_SIZE;
      s1_valid_r  <= 1'b0;
      s1_walked_r <= 1'b0;
      fwd_valid_r <= 1'b0;
      wk_rd_more_r  <= 1'b0;
      wk_wb_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg.init) begin
        clr_idx_r   <= '0;
        free_r      <= cfg.init_size;
        s1_valid_r  <= 1'b0;
        fwd_valid_r <= 1'b0;
      end else begin
        free_r <= free_nxt;
        if (state_r == CS_CLEAR) begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
        if (accept) begin
          s1_valid_r  <= 1'b1;
          s1_walked_r <= 1'b0;
        end else if (s1_fire) begin
          s1_valid_r <= 1'b0;
        end else if ((state_r == CS_WALK) && wk_last) begin
          s1_walked_r <= 1'b1;
        end
        if (s1_fire) begin
          fwd_valid_r <= data_we;
        end
      end
      if (range_go) begin
        wk_rd_more_r  <= 1'b1;
        wk_wb_valid_r <= 1'b0;
      end else if (state_r == CS_WALK) begin
        wk_wb_valid_r <= wk_rd_more_r;
        if (wk_rd_more_r) begin
          wk_rd_more_r <= wk_rd_addr_r != s1_item_r.end_addr;
        end
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      fwd_addr_r <= s1_item_r.addr;
      fwd_data_r <= s1_item_r.wdata;
      out_item_r.rdata <= ((s1_item_r.op == OP_READ) && (s1_status == ST_OK)) ? data_fwd : '0;
      out_item_r.status     <= s1_status;
      out_item_r.free_bytes <= free_r;
    end
    if (range_go) begin
      wk_rd_addr_r <= s1_item_r.addr;
    end else if ((state_r == CS_WALK) && wk_rd_more_r) begin
      wk_rd_addr_r <= wk_rd_addr_r + 1'b1;
      wk_wb_addr_r <= wk_rd_addr_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= cfg.eff_size)
    else $error("free count above memory size");

  a_walk_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_WALK) && wk_wb_valid_r && wk_rd_more_r |-> wk_wb_addr_r != wk_rd_addr_r)
    else $error("walk reads and writes the same tag");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !s1_valid_r || s1_fire)
    else $error("accepted transaction overwrites pending one");

  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_WALK) && wk_last && !cfg.init |=> (state_r == CS_RUN) && s1_walked_r)
    else $error("range walk finished without pending result");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/otbm_ram.sv -----
// synchronous simple dual port ram with registered read data
`default_nettype none
module otbm_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/otbm_cfg.sv -----
// apb register block holding mem_size
`default_nettype none
module otbm_cfg
  import otbm_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output      logic [APB_DATA_BITS-1:0] prdata,
  output      logic                     pready,
  output      cfg_t                     cfg
);

  localparam logic [16:0] MEM_BYTES_W = 17'(MEM_BYTES);
  localparam logic [SIZE_BITS-1:0] RESET_SIZE = SIZE_BITS'((MEM_BYTES < 4096) ? MEM_BYTES : 4096);

  logic [SIZE_BITS-1:0] mem_size_r;
  logic [SIZE_BITS-1:0] eff_size_r;
  logic                 wr_fire;
  logic [SIZE_BITS-1:0] wr_size;
  logic [SIZE_BITS-1:0] wr_eff;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_MEM_SIZE);
  assign wr_size = pwdata[SIZE_BITS-1:0];
  assign wr_eff  = (17'(wr_size) > MEM_BYTES_W) ? MEM_BYTES_W[SIZE_BITS-1:0] : wr_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= SIZE_BITS'(4096);
      eff_size_r <= RESET_SIZE;
    end else if (wr_fire) begin
      mem_size_r <= wr_size;
      eff_size_r <= wr_eff;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_MEM_SIZE) begin
      prdata = APB_DATA_BITS'(mem_size_r);
    end
  end

  assign cfg.mem_size  = mem_size_r;
  assign cfg.eff_size  = eff_size_r;
  assign cfg.init      = wr_fire;
  assign cfg.init_size = wr_eff;

endmodule
`default_nettype wire

// ----- tb/sv/otbm_checker.sv -----
// result checker for the owner tagged byte memory: predicts every transaction and compares
module otbm_checker
  import otbm_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire in_item_t                 in_item,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire out_item_t                out_item,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  input  wire logic                     pready,
  output int                            pending,
  output int                            fails
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_BITS-1:0] MEM_SIZE_ADDR =
    APB_ADDR_BITS'(4 * int'(REG_IDX_MEM_SIZE));

  logic [DATA_BITS-1:0] byte_mem     [MEM_BYTES];
  logic [TAG_BITS-1:0]  tag_mem      [MEM_BYTES];
  bit                   byte_written [MEM_BYTES];
  int                   eff_size;
  int                   free_cnt;
  out_item_t            result_q [$];

  task automatic reinit(input int size);
    eff_size = (size > MEM_BYTES) ? MEM_BYTES : size;
    free_cnt = eff_size;
    for (int i = 0; i < MEM_BYTES; i++) begin
      byte_mem[i]     = '0;
      tag_mem[i]      = NO_OWNER;
      byte_written[i] = 1'b0;
    end
  endtask

  task automatic predict(input in_item_t it, output out_item_t res);
    logic [TAG_BITS-1:0] own;
    logic [TAG_BITS-1:0] newtag;
    int                  a;
    int                  b;
    bit                  was_free;
    own        = it.owner_id;
    a          = it.addr;
    b          = it.end_addr;
    res.rdata  = '0;
    res.status = ST_OK;
    if (it.op == OP_READ || it.op == OP_WRITE) begin
      if (a >= eff_size) begin
        res.status = ST_BAD_ADDR;
      end else if (tag_mem[a] != own) begin
        res.status = ST_OWNER_MISMATCH;
      end else if (it.op == OP_READ) begin
        res.rdata = byte_mem[a];
      end else begin
        byte_mem[a]     = it.wdata;
        byte_written[a] = 1'b1;
      end
    end else begin
      newtag = (it.op == OP_CLAIM) ? own : NO_OWNER;
      if (a >= eff_size || b >= eff_size) begin
        res.status = ST_BAD_ADDR;
      end else if (b < a) begin
        res.status = ST_END_BEFORE_START;
      end else if (it.op == OP_CLAIM && own[TAG_BITS-1] && own != NO_OWNER) begin
        res.status = ST_BAD_OWNER;
      end else begin
        for (int i = a; i <= b; i++) begin
          was_free = (tag_mem[i] == NO_OWNER);
          if (was_free && newtag != NO_OWNER && free_cnt > 0) begin
            free_cnt--;
          end else if (!was_free && newtag == NO_OWNER) begin
            free_cnt++;
          end
          tag_mem[i] = newtag;
        end
      end
    end
    res.free_bytes = SIZE_BITS'(free_cnt);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      reinit(4096);
      result_q.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MEM_SIZE_ADDR) begin
        reinit(int'(pwdata[SIZE_BITS-1:0]));
      end
      if (in_valid && in_ready) begin
        predict(in_item, want);
        result_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_item;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected transaction: rdata %0h status %0d free_bytes %0d",
                   $time, got.rdata, got.status, got.free_bytes);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (got.rdata !== want.rdata) begin
            $display("%0t: rdata expected %0h actual %0h", $time, want.rdata, got.rdata);
            fails++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fails++;
          end
          if (got.free_bytes !== want.free_bytes) begin
            $display("%0t: free_bytes expected %0d actual %0d",
                     $time, want.free_bytes, got.free_bytes);
            fails++;
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ----- tb/sv/owner_tagged_byte_memory_tb.sv -----
// testbench top for the owner tagged byte memory: clock, reset, stimulus and verdict
module owner_tagged_byte_memory_tb
  import otbm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_BYTES = 4096;
  localparam logic [APB_ADDR_BITS-1:0] MEM_SIZE_ADDR =
    APB_ADDR_BITS'(4 * int'(REG_IDX_MEM_SIZE));

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  in_item_t                 in_item;
  logic                     out_valid;
  logic                     out_ready;
  out_item_t                out_item;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  int                       pending;
  int                       fails;
  bit                       send_calm;

  owner_tagged_byte_memory #(.MEM_BYTES(MEM_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  otbm_checker #(.MEM_BYTES(MEM_BYTES)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .pending(pending), .fails(fails)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TAG_BITS-1:0] pick_owner();
    int r;
    r = $urandom_range(99);
    if (r < 20) return NO_OWNER;
    if (r < 80) return TAG_BITS'($urandom_range(5));
    if (r < 88) return TAG_BITS'(126);
    return TAG_BITS'($urandom);
  endfunction

  function automatic int pick_addr(int size);
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range((size < 64) ? size - 1 : 63);
    if (r < 92) return $urandom_range(size - 1);
    return $urandom_range(4095);
  endfunction

  function automatic in_item_t txn(op_t op, int a0, int a1, int wd, int own);
    in_item_t it;
    it.op       = op;
    it.addr     = ADDR_BITS'(a0);
    it.end_addr = ADDR_BITS'(a1);
    it.wdata    = DATA_BITS'(wd);
    it.owner_id = TAG_BITS'(own);
    return it;
  endfunction

  // aims byte accesses at the current tags and ranges inside the memory so that most get through
  function automatic in_item_t rand_item(int size);
    in_item_t it;
    int       r;
    int       a;
    int       len;
    r           = $urandom_range(99);
    a           = pick_addr(size);
    it.addr     = ADDR_BITS'(a);
    it.end_addr = ADDR_BITS'($urandom);
    it.wdata    = DATA_BITS'($urandom);
    it.owner_id = pick_owner();
    if (r < 55) begin
      it.op = (r < 30) ? OP_WRITE : OP_READ;
      if (a < size && $urandom_range(99) < 75) it.owner_id = chk.tag_mem[a];
      // never read back a byte that holds no written data
      if (it.op == OP_READ && a < size && chk.tag_mem[a] == it.owner_id &&
          !chk.byte_written[a]) begin
        it.op = OP_WRITE;
      end
    end else begin
      it.op = (r < 80) ? OP_CLAIM : OP_RELEASE;
      r = $urandom_range(99);
      if (r < 3) begin
        it.addr     = '0;
        it.end_addr = ADDR_BITS'(size - 1);
      end else if (r < 88) begin
        len         = $urandom_range(15);
        it.end_addr = ADDR_BITS'((a + len < size) ? a + len : size - 1);
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if ($urandom_range(59) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= MEM_SIZE_ADDR;
    pwdata  <= APB_DATA_BITS'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : sink_stall
    int hold;
    bit calm;
    hold      = 0;
    calm      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(199) == 0) calm = !calm;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm) hold = pick_gap();
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int sizes [5];
    int counts [5];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    send_calm = 1'b0;
    sizes     = '{1, 37, 4096, 0, 600};
    counts    = '{50, 150, 180, 150, 100};
    sizes[3]  = $urandom_range(2, 4095);
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    send_item(txn(OP_WRITE, 0, 0, 8'hA5, -1));
    send_item(txn(OP_READ, 0, 0, 0, -1));
    send_item(txn(OP_CLAIM, 0, 15, 0, 5));
    send_item(txn(OP_READ, 0, 0, 0, -1));
    send_item(txn(OP_WRITE, 15, 0, 8'hFF, 5));
    send_item(txn(OP_READ, 15, 0, 0, 5));
    send_item(txn(OP_WRITE, 4095, 0, 8'h5A, -1));
    send_item(txn(OP_READ, 4095, 0, 0, -1));
    send_item(txn(OP_CLAIM, 4095, 0, 0, 3));
    send_item(txn(OP_CLAIM, 10, 20, 0, -128));
    send_item(txn(OP_RELEASE, 8, 12, 0, -128));
    send_item(txn(OP_CLAIM, 0, 31, 0, -1));
    send_item(txn(OP_RELEASE, 0, 31, 0, 2));
    send_item(txn(OP_CLAIM, 0, 4095, 0, 126));
    send_item(txn(OP_READ, 4095, 0, 0, -128));
    send_item(txn(OP_WRITE, 100, 0, 8'h3C, 126));
    send_item(txn(OP_READ, 100, 0, 0, 126));
    send_item(txn(OP_RELEASE, 0, 4095, 0, 0));

    for (int p = 0; p < 5; p++) begin
      drain();
      cfg_write(sizes[p]);
      if (p == 0) begin
        send_item(txn(OP_READ, 1, 0, 0, -1));
        send_item(txn(OP_CLAIM, 5, 0, 0, 0));
        send_item(txn(OP_CLAIM, 0, 1, 0, 0));
        send_item(txn(OP_WRITE, 0, 0, 8'h81, -1));
        send_item(txn(OP_READ, 0, 0, 0, -1));
        send_item(txn(OP_CLAIM, 0, 0, 0, 0));
        send_item(txn(OP_RELEASE, 0, 0, 0, 7));
      end
      for (int k = 0; k < counts[p]; k++) begin
        if (k == counts[p] / 2) drain();
        send_item(rand_item(sizes[p]));
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
